// ===== rtl/dpt_pkg.sv =====
`default_nettype none
package dpt_pkg;

	localparam int ADDR_WIDTH  = 16;
	localparam int KEY_BITS    = 64;
	localparam int LENGTH_BITS = 20;

	localparam int TABLE_DEPTH = 1 << ADDR_WIDTH;

	// port field widths
	localparam int KEY_W      = 64;
	localparam int LEN_W      = 20;
	localparam int TADDR_W    = 16;
	localparam int THRESH_W   = 32;
	localparam int SHIFT_W    = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int S_TDATA_W  = 152;
	localparam int M_TDATA_W  = 104;
	localparam int M_TUSER_W  = 3;

	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

	typedef enum logic [M_TUSER_W-1:0] {
		ST_NOT_DIST  = 3'd0,
		ST_ABANDONED = 3'd1,
		ST_STORED    = 3'd2,
		ST_REPLACED  = 3'd3,
		ST_COLLISION = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NONCE        = 3'd0,
		REG_ZERO_BITS    = 3'd1,
		REG_ADDRESS_BITS = 3'd2,
		REG_CHECK_BITS   = 3'd3,
		REG_THRESHOLD    = 3'd4,
		REG_MAX_TRAIL    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [KEY_W-1:0]    nonce;
		logic [SHIFT_W-1:0]  zero_bits;
		logic [SHIFT_W-1:0]  address_bits;
		logic [SHIFT_W-1:0]  check_bits;
		logic [THRESH_W-1:0] threshold;
		logic [LEN_W-1:0]    max_trail;
	} cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0] seed_key;
		logic             seed_side;
		logic [KEY_W-1:0] tail_key;
		logic             tail_side;
		logic [LEN_W-1:0] trail_length;
	} item_t;

	typedef struct packed {
		logic                  abandon;
		logic                  dp_hit;
		logic [ADDR_WIDTH-1:0] addr;
	} class_t;

	typedef struct packed {
		logic                   valid;
		logic [KEY_BITS-1:0]    seed_key;
		logic [KEY_BITS-1:0]    tail_key;
		logic                   seed_side;
		logic                   tail_side;
		logic [LENGTH_BITS-1:0] length;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ===== rtl/dpt_ram.sv =====
`default_nettype none
module dpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/dpt_cfg.sv =====
`default_nettype none
module dpt_cfg import dpt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr,
	input  wire logic [CFG_IDX_W-1:0]  index,
	input  wire logic [CFG_DATA_W-1:0] data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.nonce        <= '0;
			cfg_q.zero_bits    <= '0;
			cfg_q.address_bits <= SHIFT_W'(16);
			cfg_q.check_bits   <= '0;
			cfg_q.threshold    <= THRESH_W'(1);
			cfg_q.max_trail    <= {LEN_W{1'b1}};
		end else if (wr) begin
			unique case (reg_idx_t'(index))
				REG_NONCE:        cfg_q.nonce        <= data;
				REG_ZERO_BITS:    cfg_q.zero_bits    <= data[SHIFT_W-1:0];
				REG_ADDRESS_BITS: cfg_q.address_bits <= data[SHIFT_W-1:0];
				REG_CHECK_BITS:   cfg_q.check_bits   <= data[SHIFT_W-1:0];
				REG_THRESHOLD:    cfg_q.threshold    <= data[THRESH_W-1:0];
				REG_MAX_TRAIL:    cfg_q.max_trail    <= data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/dpt_classify.sv =====
`default_nettype none
module dpt_classify import dpt_pkg::*; (
	input  cfg_t   cfg,
	input  item_t  item,
	output class_t cls
);

	logic [KEY_W-1:0]   v;
	logic [KEY_W-1:0]   zmask;
	logic [KEY_W-1:0]   sh_addr;
	logic [KEY_W-1:0]   sh_chk;
	logic [SHIFT_W-1:0] abits;
	logic [5:0]         chk_shift;
	logic [31:0]        amask;
	logic [THRESH_W-1:0] cmask;
	logic [THRESH_W-1:0] chk;

	always_comb begin
		v = (item.tail_key ^ cfg.nonce) & KEY_MASK;
		// address width saturates at the table size
		abits = (cfg.address_bits > SHIFT_W'(ADDR_WIDTH)) ? SHIFT_W'(ADDR_WIDTH)
		                                                   : cfg.address_bits;
		zmask     = (KEY_W'(1) << cfg.zero_bits) - KEY_W'(1);
		sh_addr   = v >> cfg.zero_bits;
		amask     = (32'd1 << abits) - 32'd1;
		chk_shift = 6'(cfg.zero_bits) + 6'(abits);
		sh_chk    = v >> chk_shift;
		cmask     = THRESH_W'((KEY_W'(1) << cfg.check_bits) - KEY_W'(1));
		chk       = sh_chk[THRESH_W-1:0] & cmask;

		cls.abandon = item.trail_length >= cfg.max_trail;
		cls.dp_hit  = ((v & zmask) == '0) && (chk < cfg.threshold);
		cls.addr    = sh_addr[ADDR_WIDTH-1:0] & amask[ADDR_WIDTH-1:0];
	end

endmodule
`default_nettype wire

// ===== rtl/distinguished_point_table.sv =====
// Channel  Dir  Fields (low bit up)                                  Handshake
// s_       in   tdata: seed_key, seed_side, tail_key, tail_side,     tvalid/tready
//                      trail_length
// m_       out  tuser: status; tdata: table_address, old_seed_key,   tvalid/tready
//                      old_seed_side, old_length
// cfg_     in   cfg_index, cfg_data (register write)                 cfg_valid/cfg_ready
//
// One word in the lookup at a time: a table read in the stage after accept, compare
// and write-back in the next, so each lookup sees the previous word's write.
// After reset a clearing pass zeroes all 2**ADDR_WIDTH (65536) entries, one per
// cycle; s_tready stays low until it is done. Config writes are taken anytime.
// A stalled m_ channel holds the word in flight; one result waits in the output
// register while the next word is already looked up.
`default_nettype none
module distinguished_point_table import dpt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// seed_key[63:0], seed_side[64], tail_key[128:65], tail_side[129],
	// trail_length[149:130], zero pad
	input  wire logic [S_TDATA_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// table_address[15:0], old_seed_key[79:16], old_seed_side[80],
	// old_length[100:81], zero pad
	output logic      [M_TDATA_W-1:0]  m_tdata,
	// status[2:0]
	output logic      [M_TUSER_W-1:0]  m_tuser,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg;
	item_t  item_in;
	item_t  item_s1, item_s2;
	class_t cls, cls_s2;
	logic   s1_q, s2_q;
	logic   accept, s2_done;

	logic [ADDR_WIDTH:0]   clr_cnt_q;
	logic                  clr_done;

	logic                  ram_we;
	logic [ADDR_WIDTH-1:0] ram_waddr;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic [ENTRY_W-1:0]    ram_rdata;
	entry_t                rd_entry, wr_entry;

	status_t               status;
	logic [TADDR_W-1:0]    res_addr;
	logic [KEY_W-1:0]      res_seed;
	logic                  res_side;
	logic [LEN_W-1:0]      res_len;

	logic                  m_tvalid_q;
	status_t               status_q;
	logic [TADDR_W-1:0]    addr_q;
	logic [KEY_W-1:0]      seed_q;
	logic                  side_q;
	logic [LEN_W-1:0]      len_q;

	assign cfg_ready = 1'b1;

	dpt_cfg u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (cfg_valid),
		.index (cfg_index),
		.data  (cfg_data),
		.cfg   (cfg)
	);

	always_comb begin
		item_in.seed_key     = s_tdata[63:0];
		item_in.seed_side    = s_tdata[64];
		item_in.tail_key     = s_tdata[128:65];
		item_in.tail_side    = s_tdata[129];
		item_in.trail_length = s_tdata[149:130];
	end

	dpt_classify u_classify (
		.cfg (cfg),
		.item(item_s1),
		.cls (cls)
	);

	// clearing pass
	assign clr_done = clr_cnt_q[ADDR_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (!clr_done) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign s2_done  = s2_q && (!m_tvalid_q || m_tready);
	assign s_tready = clr_done && !s1_q && (!s2_q || s2_done);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= 1'b0;
			s2_q <= 1'b0;
		end else begin
			s1_q <= accept;
			if (s1_q) begin
				s2_q <= 1'b1;
			end else if (s2_done) begin
				s2_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
		end
		if (s1_q) begin
			item_s2 <= item_s1;
			cls_s2  <= cls;
		end
	end

	dpt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (s1_q),
		.raddr(cls.addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		rd_entry = entry_t'(ram_rdata);

		wr_entry.valid     = 1'b1;
		wr_entry.seed_key  = item_s2.seed_key[KEY_BITS-1:0];
		wr_entry.tail_key  = item_s2.tail_key[KEY_BITS-1:0];
		wr_entry.seed_side = item_s2.seed_side;
		wr_entry.tail_side = item_s2.tail_side;
		wr_entry.length    = LENGTH_BITS'(item_s2.trail_length);

		if (!clr_done) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q[ADDR_WIDTH-1:0];
			ram_wdata = '0;
		end else begin
			ram_we    = s2_done && !cls_s2.abandon && cls_s2.dp_hit;
			ram_waddr = cls_s2.addr;
			ram_wdata = wr_entry;
		end

		res_addr = '0;
		res_seed = '0;
		res_side = 1'b0;
		res_len  = '0;
		if (cls_s2.abandon) begin
			status = ST_ABANDONED;
		end else if (!cls_s2.dp_hit) begin
			status = ST_NOT_DIST;
		end else begin
			res_addr = TADDR_W'(cls_s2.addr);
			if (!rd_entry.valid) begin
				status = ST_STORED;
			end else if (rd_entry.tail_key == item_s2.tail_key[KEY_BITS-1:0] &&
			             rd_entry.tail_side == item_s2.tail_side) begin
				status   = ST_COLLISION;
				res_seed = KEY_W'(rd_entry.seed_key);
				res_side = rd_entry.seed_side;
				res_len  = LEN_W'(rd_entry.length);
			end else begin
				status = ST_REPLACED;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s2_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_done) begin
			status_q <= status;
			addr_q   <= res_addr;
			seed_q   <= res_seed;
			side_q   <= res_side;
			len_q    <= res_len;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b000, len_q, side_q, seed_q, addr_q};

endmodule
`default_nettype wire

// ===== rtl/dpt_checker.sv =====
`default_nettype none
module dpt_checker import dpt_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [M_TDATA_W-1:0]  m_tdata,
	input wire logic [M_TUSER_W-1:0]  m_tuser,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one word in the lookup path at a time
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word accepted during lookup");

	// previous entry is reported only on a collision
	a_old_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_COLLISION |-> m_tdata[100:16] == '0)
		else $error("old entry fields set without collision");

	// no address unless the point reached the table
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_NOT_DIST || m_tuser == ST_ABANDONED)
		|-> m_tdata[15:0] == '0)
		else $error("address reported for a point that skipped the table");

	// config port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind distinguished_point_table dpt_checker u_dpt_checker (.*);
`default_nettype wire

// ===== sim/distinguished_point_table_test.sv =====
`default_nettype none
module distinguished_point_table_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dpt_pkg::*;

	typedef struct {
		status_t            status;
		logic [TADDR_W-1:0] addr;
		logic [KEY_W-1:0]   old_seed;
		logic               old_side;
		logic [LEN_W-1:0]   old_len;
	} verdict_t;

	typedef struct {
		reg_idx_t              idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	typedef enum int {
		K_SPREAD,   // distinguished, any address
		K_CLUSTER,  // distinguished, few addresses
		K_REPEAT,   // earlier tail point again
		K_FLIP,     // earlier tail key, other side
		K_NOISE,    // raw random tail
		K_STALE     // length at or past max_trail
	} trail_kind_t;

	localparam logic [KEY_W-1:0] ALL_ONES = '1;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	distinguished_point_table u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// register mirror, reset values
	logic [KEY_W-1:0]    nonce_r = '0;
	logic [SHIFT_W-1:0]  zbits_r = '0;
	logic [SHIFT_W-1:0]  abits_r = 5'd16;
	logic [SHIFT_W-1:0]  cbits_r = '0;
	logic [THRESH_W-1:0] thresh_r = 32'd1;
	logic [LEN_W-1:0]    maxtrail_r = 20'hFFFFF;

	// table mirror
	bit                     occupied      [TABLE_DEPTH];
	logic [KEY_BITS-1:0]    seed_mem      [TABLE_DEPTH];
	logic [KEY_BITS-1:0]    tail_mem      [TABLE_DEPTH];
	bit                     seed_side_mem [TABLE_DEPTH];
	bit                     tail_side_mem [TABLE_DEPTH];
	logic [LENGTH_BITS-1:0] len_mem       [TABLE_DEPTH];

	item_t      trail_q[$];
	verdict_t   pending_verdicts[$];
	reg_write_t reg_q[$];
	logic [64:0] tail_pool[$];  // {side, key} of recent distinguished tails

	int unsigned queued = 0, accepted = 0;
	int unsigned regs_queued = 0, regs_done = 0;
	int unsigned mismatches = 0;
	int unsigned send_gap = 0, recv_gap = 0;
	bit          send_calm = 1'b0, recv_calm = 1'b0;
	item_t       on_bus;

	function automatic logic [63:0] low_ones(int unsigned n);
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic int unsigned addr_span();
		return (abits_r > 5'(ADDR_WIDTH)) ? ADDR_WIDTH : 32'(abits_r);
	endfunction

	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		r = $urandom_range(99);
		if (calm || r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// expected outcome of one trail end; updates the table mirror
	function automatic verdict_t probe_table(item_t it);
		verdict_t              r;
		logic [63:0]           v, a, chk;
		int unsigned           ab;
		logic [ADDR_WIDTH-1:0] i;
		bit                    is_dp;
		r.status = ST_NOT_DIST;
		r.addr = '0;
		r.old_seed = '0;
		r.old_side = 1'b0;
		r.old_len = '0;
		if (it.trail_length >= maxtrail_r) begin
			r.status = ST_ABANDONED;
			return r;
		end
		ab = addr_span();
		v = (it.tail_key ^ nonce_r) & KEY_MASK;
		is_dp = (v & low_ones(32'(zbits_r))) == '0;
		a = (v >> zbits_r) & low_ones(ab);
		chk = (v >> (zbits_r + ab)) & low_ones(32'(cbits_r));
		if (chk >= thresh_r)
			is_dp = 1'b0;
		if (!is_dp)
			return r;
		i = a[ADDR_WIDTH-1:0];
		r.addr = a[TADDR_W-1:0];
		if (!occupied[i]) begin
			r.status = ST_STORED;
		end else if (tail_mem[i] == (it.tail_key & KEY_MASK) &&
				tail_side_mem[i] == it.tail_side) begin
			r.status = ST_COLLISION;
			r.old_seed = seed_mem[i];
			r.old_side = seed_side_mem[i];
			r.old_len = len_mem[i];
		end else begin
			r.status = ST_REPLACED;
		end
		occupied[i] = 1'b1;
		seed_mem[i] = it.seed_key & KEY_MASK;
		tail_mem[i] = it.tail_key & KEY_MASK;
		seed_side_mem[i] = it.seed_side;
		tail_side_mem[i] = it.tail_side;
		len_mem[i] = it.trail_length[LENGTH_BITS-1:0];
		return r;
	endfunction

	function automatic item_t make_trail(trail_kind_t kind);
		item_t       it;
		logic [63:0] v, a, chk, lim;
		logic [64:0] pick;
		int unsigned ab, pos;
		it.seed_key = {$urandom, $urandom};
		it.seed_side = 1'($urandom_range(1));
		it.tail_key = {$urandom, $urandom};
		it.tail_side = 1'($urandom_range(1));
		if (maxtrail_r == 0)
			it.trail_length = LEN_W'($urandom);
		else
			it.trail_length = LEN_W'($urandom_range(maxtrail_r - 1, 0));
		case (kind)
			K_SPREAD, K_CLUSTER: begin
				ab = addr_span();
				v = {$urandom, $urandom} & ~low_ones(32'(zbits_r));
				a = (kind == K_CLUSTER) ? 64'($urandom_range(7)) : {$urandom, $urandom};
				v = (v & ~(low_ones(ab) << zbits_r)) | ((a & low_ones(ab)) << zbits_r);
				if (thresh_r != 0 && cbits_r != 0) begin
					lim = 64'(thresh_r) - 64'd1;
					if (lim > low_ones(32'(cbits_r)))
						lim = low_ones(32'(cbits_r));
					chk = 64'($urandom_range(lim[31:0], 0));
					pos = zbits_r + ab;
					v = (v & ~(low_ones(32'(cbits_r)) << pos)) | (chk << pos);
				end
				it.tail_key = v ^ nonce_r;
				tail_pool.push_back({it.tail_side, it.tail_key});
				if (tail_pool.size() > 32)
					void'(tail_pool.pop_front());
			end
			K_REPEAT, K_FLIP: begin
				if (tail_pool.size() != 0) begin
					pick = tail_pool[$urandom_range(tail_pool.size() - 1)];
					it.tail_key = pick[63:0];
					it.tail_side = pick[64] ^ (kind == K_FLIP);
				end
			end
			K_STALE: it.trail_length = LEN_W'($urandom_range(20'hFFFFF, maxtrail_r));
			default: ;
		endcase
		return it;
	endfunction

	function automatic item_t trail(logic [63:0] sk, logic ss, logic [63:0] tk, logic ts,
			logic [19:0] len);
		item_t it;
		it.seed_key = sk;
		it.seed_side = ss;
		it.tail_key = tk;
		it.tail_side = ts;
		it.trail_length = len;
		return it;
	endfunction

	function automatic void flag_mismatch(string field, logic [63:0] want, logic [63:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s expected %h got %h", $time, field, want, got);
	endfunction

	task automatic send(item_t it);
		trail_q.push_back(it);
		queued++;
	endtask

	task automatic set_reg(reg_idx_t idx, logic [63:0] d);
		reg_write_t w;
		w.idx = idx;
		w.data = d;
		reg_q.push_back(w);
		regs_queued++;
	endtask

	// wait until every word is in, every result is out and every register write is taken
	task automatic settle();
		while (accepted != queued || pending_verdicts.size() != 0 || regs_done != regs_queued)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(int unsigned n);
		int unsigned r;
		settle();
		tail_pool.delete();
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 35)
				send(make_trail(K_SPREAD));
			else if (r < 55)
				send(make_trail(K_CLUSTER));
			else if (r < 75)
				send(make_trail(K_REPEAT));
			else if (r < 80)
				send(make_trail(K_FLIP));
			else if (r < 90)
				send(make_trail(K_NOISE));
			else
				send(make_trail(K_STALE));
		end
		settle();
	endtask

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				pending_verdicts.push_back(probe_table(on_bus));
				accepted++;
			end
			if ($urandom_range(149) == 0)
				send_calm = !send_calm;
			if (!s_tvalid || s_tready) begin
				if (send_gap == 0 && trail_q.size() != 0) begin
					on_bus = trail_q.pop_front();
					s_tdata <= {2'b00, on_bus.trail_length, on_bus.tail_side, on_bus.tail_key,
						on_bus.seed_side, on_bus.seed_key};
					s_tvalid <= 1'b1;
					send_gap = pick_gap(send_calm);
				end else begin
					s_tvalid <= 1'b0;
					if (send_gap != 0)
						send_gap--;
				end
			end
		end
	end

	// register write channel; mirror follows each accepted write
	always @(posedge clk) begin
		reg_write_t w;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_idx_t'(cfg_index))
					REG_NONCE:        nonce_r = cfg_data;
					REG_ZERO_BITS:    zbits_r = cfg_data[SHIFT_W-1:0];
					REG_ADDRESS_BITS: abits_r = cfg_data[SHIFT_W-1:0];
					REG_CHECK_BITS:   cbits_r = cfg_data[SHIFT_W-1:0];
					REG_THRESHOLD:    thresh_r = cfg_data[THRESH_W-1:0];
					REG_MAX_TRAIL:    maxtrail_r = cfg_data[LEN_W-1:0];
					default: ;
				endcase
				regs_done++;
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_q.size() != 0) begin
					w = reg_q.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= w.idx;
					cfg_data <= w.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		verdict_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_verdicts.size() == 0) begin
					flag_mismatch("word with nothing expected, status", '0, 64'(m_tuser));
				end else begin
					want = pending_verdicts.pop_front();
					if (m_tuser !== want.status)
						flag_mismatch("status", 64'(want.status), 64'(m_tuser));
					if (m_tdata[15:0] !== want.addr)
						flag_mismatch("table_address", 64'(want.addr), 64'(m_tdata[15:0]));
					if (m_tdata[79:16] !== want.old_seed)
						flag_mismatch("old_seed_key", want.old_seed, m_tdata[79:16]);
					if (m_tdata[80] !== want.old_side)
						flag_mismatch("old_seed_side", 64'(want.old_side), 64'(m_tdata[80]));
					if (m_tdata[100:81] !== want.old_len)
						flag_mismatch("old_length", 64'(want.old_len), 64'(m_tdata[100:81]));
				end
				recv_gap = pick_gap(recv_calm);
			end else if (recv_gap == 0 && $urandom_range(31) == 0) begin
				recv_gap = pick_gap(recv_calm);
			end
			if ($urandom_range(149) == 0)
				recv_calm = !recv_calm;
			if (recv_gap != 0) begin
				m_tready <= 1'b0;
				recv_gap--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		#20ms;
		$display("distinguished_point_table_test: done, errors");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: every short trail is distinguished, address = low 16 bits
		send(trail(ALL_ONES, 1'b1, ALL_ONES, 1'b1, 20'd0));
		send(trail('0, 1'b0, ALL_ONES, 1'b1, 20'hFFFFE));
		send(trail(ALL_ONES, 1'b1, ALL_ONES, 1'b0, 20'd5));
		send(trail('0, 1'b0, '0, 1'b0, 20'hFFFFF));
		send(trail('0, 1'b0, '0, 1'b0, 20'd0));
		send(trail(ALL_ONES, 1'b1, 64'hFFFF_FFFF_FFFF_0000, 1'b0, 20'd7));
		send(trail(64'd5, 1'b0, 64'hFFFF_FFFF_FFFF_0000, 1'b0, 20'd0));
		send(trail(64'd9, 1'b1, 64'hFFFF_FFFF_FFFF_0000, 1'b0, 20'd1));
		settle();

		// widest fields; address setting past ADDR_WIDTH saturates
		set_reg(REG_NONCE, ALL_ONES);
		set_reg(REG_ZERO_BITS, 64'd31);
		set_reg(REG_ADDRESS_BITS, 64'd31);
		set_reg(REG_CHECK_BITS, 64'd31);
		set_reg(REG_THRESHOLD, 64'h8000_0000);
		set_reg(REG_MAX_TRAIL, 64'd1);
		settle();
		send(trail(64'h1234, 1'b1, ALL_ONES, 1'b0, 20'd0));
		send(make_trail(K_SPREAD));
		send(make_trail(K_SPREAD));
		send(make_trail(K_REPEAT));
		send(make_trail(K_STALE));
		send(make_trail(K_NOISE));
		settle();

		// zero threshold: nothing is distinguished
		set_reg(REG_THRESHOLD, 64'd0);
		settle();
		send(trail('0, 1'b0, ALL_ONES, 1'b1, 20'd0));
		send(make_trail(K_NOISE));
		settle();

		// zero max_trail: even length zero is abandoned
		set_reg(REG_THRESHOLD, 64'd1);
		set_reg(REG_MAX_TRAIL, 64'd0);
		settle();
		send(trail('0, 1'b0, ALL_ONES, 1'b0, 20'd0));
		send(make_trail(K_NOISE));
		settle();

		// no address bits: every point lands on entry zero
		set_reg(REG_NONCE, 64'd0);
		set_reg(REG_ZERO_BITS, 64'd0);
		set_reg(REG_ADDRESS_BITS, 64'd0);
		set_reg(REG_CHECK_BITS, 64'd0);
		set_reg(REG_MAX_TRAIL, 64'hFFFFF);
		settle();
		send(make_trail(K_SPREAD));
		send(make_trail(K_REPEAT));
		send(make_trail(K_FLIP));
		send(make_trail(K_NOISE));
		settle();

		for (int p = 0; p < 8; p++) begin
			case ($urandom_range(2))
				0: set_reg(REG_NONCE, 64'd0);
				1: set_reg(REG_NONCE, ALL_ONES);
				default: set_reg(REG_NONCE, {$urandom, $urandom});
			endcase
			case ($urandom_range(3))
				0: set_reg(REG_ZERO_BITS, 64'd0);
				1: set_reg(REG_ZERO_BITS, 64'd31);
				default: set_reg(REG_ZERO_BITS, 64'($urandom_range(31)));
			endcase
			case ($urandom_range(4))
				0: set_reg(REG_ADDRESS_BITS, 64'd0);
				1: set_reg(REG_ADDRESS_BITS, 64'd16);
				2: set_reg(REG_ADDRESS_BITS, 64'd31);
				default: set_reg(REG_ADDRESS_BITS, 64'($urandom_range(31)));
			endcase
			case ($urandom_range(3))
				0: set_reg(REG_CHECK_BITS, 64'd0);
				1: set_reg(REG_CHECK_BITS, 64'd31);
				default: set_reg(REG_CHECK_BITS, 64'($urandom_range(31)));
			endcase
			case ($urandom_range(3))
				0: set_reg(REG_THRESHOLD, 64'd1);
				1: set_reg(REG_THRESHOLD, 64'h8000_0000);
				default: set_reg(REG_THRESHOLD, 64'($urandom_range(32'h8000_0000, 1)));
			endcase
			case ($urandom_range(4))
				0: set_reg(REG_MAX_TRAIL, 64'd1);
				1, 2: set_reg(REG_MAX_TRAIL, 64'hFFFFF);
				default: set_reg(REG_MAX_TRAIL, 64'($urandom_range(20'hFFFFF, 1)));
			endcase
			run_phase(225);
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("distinguished_point_table_test: done, clean");
		else
			$display("distinguished_point_table_test: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
